FILE: rtl/mte_pkg.sv
// Shared types, constants and register codes for the motor thermal estimator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mte_pkg;

	// Default number of fraction bits of the temperature format
	localparam int MTE_TEMP_FRAC_BITS = 8;

	// Field widths
	localparam int CUR_W   = 17;
	localparam int SPD_W   = 16;
	localparam int TEMP_W  = 18;
	localparam int STAT_W  = 3;
	localparam int CFG_W   = 24;
	localparam int ADDR_W  = 3;
	localparam int RISE_W  = 19;

	// Arithmetic unit sizes
	localparam int NUM_W     = 88;
	localparam int DEN_W     = 60;
	localparam int Q_W       = 64;
	localparam int MUL_BW    = 25;
	localparam int MUL_ITERS = MUL_BW;
	localparam int DIV_ITERS = NUM_W;
	localparam int MUL_CNT_W = $clog2(MUL_ITERS);
	localparam int DIV_CNT_W = $clog2(DIV_ITERS);
	localparam int H_W       = 63;
	localparam int MAG_W     = 41;

	// Reset values
	localparam logic signed [15:0] AMBIENT_RESET = 16'sd10240;
	localparam logic [15:0]        RES_RESET     = 16'd1000;
	localparam logic [16:0]        RCUR_RESET    = 17'd5000;
	localparam logic [14:0]        RSPD_RESET    = 15'd3000;
	localparam logic [16:0]        TMAX_RESET    = 17'd39680;
	localparam logic [23:0]        TAU_RESET     = 24'd600000;
	localparam logic [23:0]        TS_RESET      = 24'd1000;
	localparam logic signed [TEMP_W-1:0] TEMP_RESET = 18'sd10240;

	// Register indexes
	localparam logic [ADDR_W-1:0] REG_AMBIENT  = 3'd0;
	localparam logic [ADDR_W-1:0] REG_RES      = 3'd1;
	localparam logic [ADDR_W-1:0] REG_RCUR     = 3'd2;
	localparam logic [ADDR_W-1:0] REG_RSPD     = 3'd3;
	localparam logic [ADDR_W-1:0] REG_TMAX     = 3'd4;
	localparam logic [ADDR_W-1:0] REG_TAU      = 3'd5;
	localparam logic [ADDR_W-1:0] REG_INTERVAL = 3'd6;

	// Update status codes
	localparam logic [STAT_W-1:0] ST_NORMAL  = 3'd0;
	localparam logic [STAT_W-1:0] ST_FLOOR   = 3'd1;
	localparam logic [STAT_W-1:0] ST_CAP     = 3'd2;
	localparam logic [STAT_W-1:0] ST_TAU0    = 3'd3;
	localparam logic [STAT_W-1:0] ST_RTH_BAD = 3'd4;

	// Multiply operations: operand sources and result destination
	typedef enum logic [1:0] {
		MOP_NUM  = 2'd0,	// I^2 * fnum
		MOP_DEN  = 2'd1,	// Irated^2 * fden
		MOP_RISE = 2'd2,	// * (Tmax - Ta)
		MOP_ERR  = 2'd3	// |e| * Ts
	} mul_op_t;

	// Divide result destination
	typedef enum logic {
		DOP_H   = 1'b0,
		DOP_MAG = 1'b1
	} div_op_t;

	// Controller to datapath
	typedef struct packed {
		logic    load_in;
		logic    square;
		logic    mul_start;
		mul_op_t mul_op;
		logic    div_start;
		div_op_t div_op;
		logic    err_calc;
		logic    update;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic bypass;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/mte_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on mte_pkg.
`timescale 1ns / 1ps

module mte_div import mte_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [Q_W-1:0]       q_q;
	logic                 ovf_q;

	logic [DEN_W:0]   rem_sh;
	logic             qbit;
	logic [DEN_W:0]   rem_nx;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		qbit   = (rem_sh >= {1'b0, den_q});
		rem_nx = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	assign done = busy_q && (cnt_q == DIV_CNT_W'(DIV_ITERS - 1));
	assign quo  = {q_q[Q_W-2:0], qbit};
	assign ovf  = ovf_q | q_q[Q_W-1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= rem_nx[DEN_W-1:0];
			q_q   <= quo;
			ovf_q <= ovf;
		end
	end

endmodule

FILE: rtl/mte_dp.sv
// Datapath: config registers, estimate, shift-add multiplier, result register.
// Depends on mte_pkg and mte_div.
`timescale 1ns / 1ps

module mte_dp import mte_pkg::*; #(
	parameter int TEMP_FRAC_BITS = MTE_TEMP_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               st,
	input  logic [CUR_W-1:0]    in_cur,
	input  logic signed [SPD_W-1:0] in_spd,
	input  logic                cfg_we,
	input  logic [ADDR_W-1:0]   cfg_addr,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [TEMP_W-1:0]   out_temp,
	output logic [STAT_W-1:0]   out_stat
);

	localparam int CAP_RAW = 300 << TEMP_FRAC_BITS;
	localparam int CAP_INT = (CAP_RAW > 131071) ? 131071 : CAP_RAW;
	localparam logic signed [42:0] TEMP_CAP = 43'(CAP_INT);
	localparam logic [Q_W-1:0] H_LIMIT   = Q_W'(1) << 62;
	localparam logic [Q_W-1:0] MAG_LIMIT = Q_W'(1) << 40;

	// config registers
	logic signed [15:0] ambient_q;
	logic [15:0]        res_q;
	logic [16:0]        rcur_q;
	logic [14:0]        rspd_q;
	logic [16:0]        tmax_q;
	logic [23:0]        tau_q;
	logic [23:0]        ts_q;

	// working registers
	logic signed [TEMP_W-1:0] temp_q;
	logic [CUR_W-1:0]   cur_q;
	logic [15:0]        aspd_q;
	logic [NUM_W-1:0]   p_q;
	logic [DEN_W-1:0]   dd_q;
	logic [H_W-1:0]     h_q;
	logic [Q_W-1:0]     abse_q;
	logic               eneg_q;
	logic [MAG_W-1:0]   mag_q;
	div_op_t            div_op_q;

	// multiplier registers
	logic                 mul_busy_q;
	logic [MUL_CNT_W-1:0] mul_cnt_q;
	mul_op_t              mul_op_q;
	logic [NUM_W-1:0]     mcand_q;
	logic [MUL_BW-1:0]    mplier_q;
	logic [NUM_W-1:0]     acc_q;

	// output register
	logic               out_valid_q;
	logic [TEMP_W-1:0]  out_temp_q;
	logic [STAT_W-1:0]  out_stat_q;

	logic signed [RISE_W-1:0] rise;
	logic                     rth_bad;
	logic [MUL_BW-1:0]        fnum;
	logic [MUL_BW-1:0]        fden;
	logic [NUM_W-1:0]         acc_nx;
	logic                     mul_done;
	logic [NUM_W-1:0]         mcand_src;
	logic [MUL_BW-1:0]        mplier_src;
	logic                     div_done;
	logic [Q_W-1:0]           div_quo;
	logic                     div_ovf;
	logic signed [Q_W:0]      err;
	logic signed [42:0]       nt;
	logic signed [42:0]       amb_x;
	logic signed [TEMP_W-1:0] res_temp;
	logic [STAT_W-1:0]        res_stat;

	// load factors and bypass conditions
	always_comb begin
		rise    = RISE_W'($signed({2'b00, tmax_q})) - RISE_W'(ambient_q);
		rth_bad = (rise <= 0) || (res_q == '0) || (rcur_q == '0);
		if (rspd_q != '0) begin
			fden = MUL_BW'(rspd_q) * MUL_BW'(1000);
			fnum = fden + MUL_BW'(aspd_q) * MUL_BW'(12);
		end else begin
			fden = MUL_BW'(1);
			fnum = MUL_BW'(1);
		end
	end

	// multiplier operand selection
	always_comb begin
		case (cmd.mul_op)
			MOP_NUM: begin
				mcand_src  = p_q;
				mplier_src = fnum;
			end
			MOP_DEN: begin
				mcand_src  = NUM_W'(dd_q);
				mplier_src = fden;
			end
			MOP_RISE: begin
				mcand_src  = p_q;
				mplier_src = MUL_BW'(rise[RISE_W-2:0]);
			end
			default: begin
				mcand_src  = NUM_W'(abse_q);
				mplier_src = MUL_BW'(ts_q);
			end
		endcase
	end

	// shift-add step
	assign acc_nx   = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign mul_done = mul_busy_q && (mul_cnt_q == MUL_CNT_W'(MUL_ITERS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_cnt_q  <= '0;
		end else if (cmd.mul_start) begin
			mul_busy_q <= 1'b1;
			mul_cnt_q  <= '0;
		end else if (mul_busy_q) begin
			mul_busy_q <= !mul_done;
			mul_cnt_q  <= mul_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mcand_q  <= mcand_src;
			mplier_q <= mplier_src;
			acc_q    <= '0;
			mul_op_q <= cmd.mul_op;
		end else if (mul_busy_q) begin
			mcand_q  <= {mcand_q[NUM_W-2:0], 1'b0};
			mplier_q <= mplier_q >> 1;
			acc_q    <= acc_nx;
		end
	end

	// shared divider: round(p / dd)
	mte_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (p_q + NUM_W'(dd_q >> 1)),
		.den    (dd_q),
		.done   (div_done),
		.quo    (div_quo),
		.ovf    (div_ovf)
	);

	// error term
	assign err = $signed({2'b00, h_q}) - (Q_W+1)'(temp_q) + (Q_W+1)'(ambient_q);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_q  <= in_cur;
			aspd_q <= in_spd[SPD_W-1] ? 16'(-in_spd) : 16'(in_spd);
		end
		if (cmd.square) begin
			p_q  <= NUM_W'(34'(cur_q) * 34'(cur_q));
			dd_q <= DEN_W'(34'(rcur_q) * 34'(rcur_q));
		end
		if (cmd.div_start)
			div_op_q <= cmd.div_op;
		if (mul_done) begin
			if (mul_op_q == MOP_DEN)
				dd_q <= acc_nx[DEN_W-1:0];
			else
				p_q <= acc_nx;
		end
		if (div_done) begin
			if (div_op_q == DOP_H)
				h_q <= (div_ovf || div_quo > H_LIMIT) ? H_LIMIT[H_W-1:0] : div_quo[H_W-1:0];
			else
				mag_q <= (div_ovf || div_quo > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0]
					: div_quo[MAG_W-1:0];
		end
		if (cmd.err_calc) begin
			eneg_q <= err[Q_W];
			abse_q <= err[Q_W] ? Q_W'(-err) : Q_W'(err);
			dd_q   <= DEN_W'(34'(tau_q) * 34'(1000));
		end
	end

	// new estimate: step, floor at ambient, cap; ambient if tau is zero, hold if Rth is bad
	always_comb begin
		amb_x    = 43'(ambient_q);
		nt       = eneg_q ? (43'(temp_q) - 43'(mag_q)) : (43'(temp_q) + 43'(mag_q));
		res_stat = ST_NORMAL;
		if (tau_q == '0) begin
			nt       = amb_x;
			res_stat = ST_TAU0;
		end else if (rth_bad) begin
			nt       = 43'(temp_q);
			res_stat = ST_RTH_BAD;
		end else begin
			if (nt < amb_x) begin
				nt       = amb_x;
				res_stat = ST_FLOOR;
			end
			if (nt > TEMP_CAP) begin
				nt       = TEMP_CAP;
				res_stat = ST_CAP;
			end
		end
		res_temp = nt[TEMP_W-1:0];
	end

	// config writes and estimate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambient_q <= AMBIENT_RESET;
			res_q     <= RES_RESET;
			rcur_q    <= RCUR_RESET;
			rspd_q    <= RSPD_RESET;
			tmax_q    <= TMAX_RESET;
			tau_q     <= TAU_RESET;
			ts_q      <= TS_RESET;
			temp_q    <= TEMP_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_AMBIENT:  ambient_q <= cfg_wdata[15:0];
					REG_RES:      res_q     <= cfg_wdata[15:0];
					REG_RCUR:     rcur_q    <= cfg_wdata[16:0];
					REG_RSPD:     rspd_q    <= cfg_wdata[14:0];
					REG_TMAX:     tmax_q    <= cfg_wdata[16:0];
					REG_TAU:      tau_q     <= cfg_wdata;
					REG_INTERVAL: ts_q      <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.update)
				temp_q <= res_temp;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.update)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_temp_q <= res_temp;
			out_stat_q <= res_stat;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_temp    = out_temp_q;
	assign out_stat    = out_stat_q;
	assign st.mul_done = mul_done;
	assign st.div_done = div_done;
	assign st.bypass   = (tau_q == '0) || rth_bad;
	assign st.out_free = !out_valid_q || out_ready;

endmodule

FILE: rtl/mte_ctrl.sv
// Controller: sequences square, four multiplies, two divides and the update.
// Depends on mte_pkg.
`timescale 1ns / 1ps

module mte_ctrl import mte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SQ    = 10'b0000000010,
		S_MUL_N = 10'b0000000100,
		S_MUL_D = 10'b0000001000,
		S_MUL_R = 10'b0000010000,
		S_DIV_H = 10'b0000100000,
		S_ERR   = 10'b0001000000,
		S_MUL_E = 10'b0010000000,
		S_DIV_M = 10'b0100000000,
		S_UPD   = 10'b1000000000
	} state_t;

	state_t state_q, state_nx;
	logic   issued_q, issued_nx;

	always_comb begin
		state_nx  = state_q;
		issued_nx = issued_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid)
					state_nx = S_SQ;
			end
			S_SQ: begin
				cmd.square = 1'b1;
				state_nx   = st.bypass ? S_UPD : S_MUL_N;
			end
			S_MUL_N, S_MUL_D, S_MUL_R, S_MUL_E: begin
				case (state_q)
					S_MUL_N: cmd.mul_op = MOP_NUM;
					S_MUL_D: cmd.mul_op = MOP_DEN;
					S_MUL_R: cmd.mul_op = MOP_RISE;
					default: cmd.mul_op = MOP_ERR;
				endcase
				cmd.mul_start = !issued_q;
				issued_nx     = 1'b1;
				if (st.mul_done) begin
					issued_nx = 1'b0;
					case (state_q)
						S_MUL_N: state_nx = S_MUL_D;
						S_MUL_D: state_nx = S_MUL_R;
						S_MUL_R: state_nx = S_DIV_H;
						default: state_nx = S_DIV_M;
					endcase
				end
			end
			S_DIV_H, S_DIV_M: begin
				cmd.div_op    = (state_q == S_DIV_H) ? DOP_H : DOP_MAG;
				cmd.div_start = !issued_q;
				issued_nx     = 1'b1;
				if (st.div_done) begin
					issued_nx = 1'b0;
					state_nx  = (state_q == S_DIV_H) ? S_ERR : S_UPD;
				end
			end
			S_ERR: begin
				cmd.err_calc = 1'b1;
				state_nx     = S_MUL_E;
			end
			S_UPD: begin
				if (st.out_free) begin
					cmd.update = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			issued_q <= issued_nx;
		end
	end

endmodule

FILE: rtl/motor_thermal_estimator.sv
// Top level of the motor winding temperature estimator.
// Depends on mte_pkg, mte_ctrl and mte_dp.
//
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   current [16:0], speed [32:17]
//  m_*      out        m_tvalid/m_tready   temperature [17:0], status [20:18]
//  cfg_*    in         cfg_we              cfg_addr register, cfg_wdata value
//
// Each tick runs through the shared 25-step shift-add multiplier (four passes)
// and the 88-step serial divider (two passes). Requests with zero tau or bad
// thermal resistance skip both and go from the square straight to the update.
// A new request is taken once the previous one is handed to the output
// register, which holds a result until m_tready. Reset restores defaults.
`timescale 1ns / 1ps

module motor_thermal_estimator import mte_pkg::*; #(
	parameter int TEMP_FRAC_BITS = MTE_TEMP_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,	// motor_current [16:0], motor_speed [32:17]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,	// winding_temp [17:0], update_status [20:18]
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	cmd_t               cmd;
	stat_t              st;
	logic [TEMP_W-1:0]  out_temp;
	logic [STAT_W-1:0]  out_stat;

	mte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mte_dp #(
		.TEMP_FRAC_BITS (TEMP_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_cur    (s_tdata[16:0]),
		.in_spd    (s_tdata[32:17]),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_temp  (out_temp),
		.out_stat  (out_stat)
	);

	assign m_tdata = {3'b000, out_stat, out_temp};

endmodule
